// ===== rtl/osc_pkg.sv =====
// Shared types, codes and constants for the OSC message stream parser.
`default_nettype none
package osc_pkg;

  localparam int MAX_MESSAGE_BYTES = 1024;
  localparam int MAX_TAGS          = 16;
  localparam int TAG_IDX_W         = $clog2(MAX_TAGS);
  localparam int QUEUE_DEPTH       = 4;
  localparam int QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_B     = 8'h62;

  localparam logic [1:0] TYPE_FLOAT = 2'd0;
  localparam logic [1:0] TYPE_INT   = 2'd1;
  localparam logic [1:0] TYPE_STR   = 2'd2;
  localparam logic [1:0] TYPE_BLOB  = 2'd3;

  localparam logic [3:0] PH_FIRST    = 4'd0;
  localparam logic [3:0] PH_PREFIX   = 4'd1;
  localparam logic [3:0] PH_SLASH    = 4'd2;
  localparam logic [3:0] PH_ADDR     = 4'd3;
  localparam logic [3:0] PH_PAD_ADDR = 4'd4;
  localparam logic [3:0] PH_COMMA    = 4'd5;
  localparam logic [3:0] PH_TAGS     = 4'd6;
  localparam logic [3:0] PH_PAD_TAGS = 4'd7;
  localparam logic [3:0] PH_NUM      = 4'd8;
  localparam logic [3:0] PH_STR      = 4'd9;
  localparam logic [3:0] PH_STRPAD   = 4'd10;
  localparam logic [3:0] PH_BLOBSZ   = 4'd11;
  localparam logic [3:0] PH_BLOBDATA = 4'd12;
  localparam logic [3:0] PH_BLOBPAD  = 4'd13;
  localparam logic [3:0] PH_DONE     = 4'd14;
  localparam logic [3:0] PH_DRAIN    = 4'd15;

  localparam logic [3:0] ST_OK            = 4'd0;
  localparam logic [3:0] ST_TOO_LONG      = 4'd1;
  localparam logic [3:0] ST_BAD_PREFIX    = 4'd2;
  localparam logic [3:0] ST_NO_SLASH      = 4'd3;
  localparam logic [3:0] ST_ADDR_UNTERM   = 4'd4;
  localparam logic [3:0] ST_ADDR_PAD      = 4'd5;
  localparam logic [3:0] ST_NO_COMMA      = 4'd6;
  localparam logic [3:0] ST_TAGS_UNTERM   = 4'd7;
  localparam logic [3:0] ST_BAD_TAG       = 4'd8;
  localparam logic [3:0] ST_TAG_PAD       = 4'd9;
  localparam logic [3:0] ST_ARG_OVERFLOW  = 4'd10;
  localparam logic [3:0] ST_BLOB_SIZE_OVF = 4'd11;
  localparam logic [3:0] ST_BLOB_BAD_SIZE = 4'd12;
  localparam logic [3:0] ST_TOO_MANY_TAGS = 4'd13;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } osc_in_t;

  typedef struct packed {
    logic        record_kind;
    logic [1:0]  arg_type;
    logic [3:0]  arg_number;
    logic [10:0] data_offset;
    logic [10:0] data_length;
    logic [3:0]  status;
    logic [10:0] message_size;
    logic [4:0]  arg_count;
    logic [10:0] args_offset;
    logic        out_last;
  } osc_out_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [10:0] pos;
    logic [31:0] len_prefix;
    logic        prefix;
    logic [3:0]  err;
    logic [4:0]  tag_total;
    logic [4:0]  cur;
    logic [1:0]  cur_type;
    logic [10:0] arg_start;
    logic [31:0] blob;
    logic [10:0] args_start;
    logic [10:0] raw;
    logic [12:0] seg_end;
  } osc_state_t;

  typedef struct packed {
    logic                 en;
    logic [TAG_IDX_W-1:0] idx;
    logic [1:0]           code;
  } osc_tag_wr_t;

  function automatic logic [12:0] up4(input logic [12:0] x);
    logic [12:0] s;
    s = x + 13'd3;
    return {s[12:2], 2'b00};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/osc_step.sv =====
// Per-byte next-state and record logic of the OSC parser.
`default_nettype none
module osc_step (
  input  osc_pkg::osc_state_t  cur_s,
  input  osc_pkg::osc_in_t     in_data,
  input  logic [1:0]           next_tag,
  output osc_pkg::osc_state_t  nxt_s,
  output osc_pkg::osc_tag_wr_t tag_wr,
  output logic                 desc_valid,
  output osc_pkg::osc_out_t    desc_rec,
  output logic                 sum_valid,
  output osc_pkg::osc_out_t    sum_rec
);
  import osc_pkg::*;

  always_comb begin
    osc_state_t  n;
    logic [7:0]  b;
    logic [12:0] p1;
    logic        msg;
    logic        do_cmp;
    logic        do_beg;
    logic [3:0]  st;
    logic [12:0] blob_end;

    n          = cur_s;
    b          = in_data.in_byte;
    p1         = {2'b00, cur_s.pos} + 13'd1;
    msg        = 1'b0;
    do_cmp     = 1'b0;
    do_beg     = 1'b0;
    tag_wr     = '0;
    desc_valid = 1'b0;
    desc_rec   = '0;
    sum_valid  = 1'b0;
    sum_rec    = '0;
    st         = ST_OK;
    blob_end   = {2'b00, cur_s.arg_start} + 13'd4 + {2'b00, cur_s.blob[10:0]};

    if (cur_s.raw <= 11'(MAX_MESSAGE_BYTES)) begin
      n.raw = cur_s.raw + 11'd1;
    end

    if (n.raw > 11'(MAX_MESSAGE_BYTES)) begin
      n.phase = PH_DRAIN;
    end else if (cur_s.phase == PH_FIRST) begin
      if (b == CH_SLASH) begin
        n.phase = PH_SLASH;
        msg = 1'b1;
      end else begin
        n.prefix     = 1'b1;
        n.len_prefix = {24'd0, b};
        n.phase      = PH_PREFIX;
      end
    end else if (cur_s.phase == PH_PREFIX) begin
      n.len_prefix = {cur_s.len_prefix[23:0], b};
      if (n.raw == 11'd4) begin
        if (n.len_prefix[31]) begin
          if (n.err == ST_OK) n.err = ST_BAD_PREFIX;
          n.phase = PH_DRAIN;
        end else begin
          n.phase = PH_SLASH;
        end
      end
    end else if (cur_s.phase != PH_DRAIN) begin
      if (!cur_s.prefix || ({21'd0, cur_s.pos} < cur_s.len_prefix)) msg = 1'b1;
    end

    if (msg) begin
      n.pos = cur_s.pos + 11'd1;
      case (n.phase)
        PH_SLASH: begin
          if (b != CH_SLASH) begin
            if (n.err == ST_OK) n.err = ST_NO_SLASH;
            n.phase = PH_DRAIN;
          end else begin
            n.phase = PH_ADDR;
          end
        end
        PH_ADDR: begin
          if (b == 8'd0) begin
            n.seg_end = up4(p1);
            n.phase   = (n.seg_end == p1) ? PH_COMMA : PH_PAD_ADDR;
          end
        end
        PH_PAD_ADDR: begin
          if (p1 == cur_s.seg_end) n.phase = PH_COMMA;
        end
        PH_COMMA: begin
          if (b != CH_COMMA) begin
            if (n.err == ST_OK) n.err = ST_NO_COMMA;
            n.phase = PH_DRAIN;
          end else begin
            n.phase = PH_TAGS;
          end
        end
        PH_TAGS: begin
          if (b == 8'd0) begin
            if (cur_s.err != ST_OK) begin
              n.phase = PH_DRAIN;
            end else begin
              n.seg_end    = up4(p1);
              n.args_start = n.seg_end[10:0];
              if (n.seg_end == p1) begin
                n.arg_start = n.args_start;
                do_beg = 1'b1;
              end else begin
                n.phase = PH_PAD_TAGS;
              end
            end
          end else if (b != CH_F && b != CH_I && b != CH_S && b != CH_B) begin
            if (n.err == ST_OK) n.err = ST_BAD_TAG;
          end else if (cur_s.tag_total >= 5'(MAX_TAGS)) begin
            if (n.err == ST_OK) n.err = ST_TOO_MANY_TAGS;
          end else begin
            tag_wr.en  = 1'b1;
            tag_wr.idx = cur_s.tag_total[TAG_IDX_W-1:0];
            tag_wr.code = (b == CH_F) ? TYPE_FLOAT : (b == CH_I) ? TYPE_INT :
                          (b == CH_S) ? TYPE_STR : TYPE_BLOB;
            n.tag_total = cur_s.tag_total + 5'd1;
          end
        end
        PH_PAD_TAGS: begin
          if (p1 == cur_s.seg_end) begin
            n.arg_start = cur_s.args_start;
            do_beg = 1'b1;
          end
        end
        PH_NUM, PH_STRPAD, PH_BLOBPAD: begin
          if (p1 == cur_s.seg_end) do_cmp = 1'b1;
        end
        PH_STR: begin
          if (b == 8'd0) begin
            n.blob    = {21'd0, cur_s.pos - cur_s.arg_start};
            n.seg_end = up4(p1);
            if (n.seg_end == p1) do_cmp = 1'b1;
            else n.phase = PH_STRPAD;
          end
        end
        PH_BLOBSZ: begin
          n.blob = {cur_s.blob[23:0], b};
          if ({1'b0, cur_s.pos} == {1'b0, cur_s.arg_start} + 12'd3) begin
            if (n.blob[31] || n.blob > 32'(MAX_MESSAGE_BYTES)) begin
              if (n.err == ST_OK) n.err = ST_BLOB_BAD_SIZE;
              n.phase = PH_DRAIN;
            end else begin
              n.seg_end = up4({2'b00, cur_s.arg_start} + 13'd4 + {2'b00, n.blob[10:0]});
              if (n.blob == 32'd0) do_cmp = 1'b1;
              else n.phase = PH_BLOBDATA;
            end
          end
        end
        PH_BLOBDATA: begin
          if (p1 == blob_end) begin
            if (cur_s.seg_end == p1) do_cmp = 1'b1;
            else n.phase = PH_BLOBPAD;
          end
        end
        default: ;
      endcase
    end

    // emit the finished argument, then open the next one
    if (do_cmp) begin
      desc_valid           = 1'b1;
      desc_rec.arg_type    = n.cur_type;
      desc_rec.arg_number  = n.cur[3:0];
      desc_rec.data_offset = (n.cur_type == TYPE_BLOB) ? n.arg_start + 11'd4 : n.arg_start;
      desc_rec.data_length = (n.cur_type >= TYPE_STR) ? n.blob[10:0] : 11'd4;
      n.arg_start = n.seg_end[10:0];
      n.cur       = n.cur + 5'd1;
      do_beg      = 1'b1;
    end

    if (do_beg) begin
      if (n.cur >= n.tag_total || n.cur >= 5'(MAX_TAGS)) begin
        n.phase = PH_DONE;
      end else begin
        n.cur_type = next_tag;
        n.blob     = 32'd0;
        if (next_tag < TYPE_STR) begin
          n.phase   = PH_NUM;
          n.seg_end = {2'b00, n.arg_start} + 13'd4;
        end else if (next_tag == TYPE_STR) begin
          n.phase = PH_STR;
        end else begin
          n.phase = PH_BLOBSZ;
        end
      end
    end

    if (in_data.in_last) begin
      if (n.raw > 11'(MAX_MESSAGE_BYTES)) begin
        st = ST_TOO_LONG;
      end else if (n.prefix && n.raw >= 11'd4 &&
                   n.len_prefix > {21'd0, n.raw - 11'd4}) begin
        st = ST_BAD_PREFIX;
      end else begin
        case (n.phase)
          PH_FIRST, PH_PREFIX, PH_SLASH: st = ST_NO_SLASH;
          PH_ADDR:                       st = ST_ADDR_UNTERM;
          PH_PAD_ADDR, PH_COMMA:         st = ST_ADDR_PAD;
          PH_TAGS:                       st = ST_TAGS_UNTERM;
          PH_PAD_TAGS:                   st = ST_TAG_PAD;
          PH_BLOBSZ:                     st = ST_BLOB_SIZE_OVF;
          PH_BLOBDATA:                   st = ST_BLOB_BAD_SIZE;
          PH_DONE:                       st = ST_OK;
          PH_DRAIN:                      st = n.err;
          default:                       st = ST_ARG_OVERFLOW;
        endcase
      end
      sum_valid           = 1'b1;
      sum_rec.record_kind = 1'b1;
      sum_rec.out_last    = 1'b1;
      sum_rec.status      = st;
      if (st == ST_OK) begin
        sum_rec.message_size = n.arg_start;
        sum_rec.arg_count    = n.tag_total;
        sum_rec.args_offset  = n.args_start;
      end
      n       = '0;
      n.phase = PH_FIRST;
    end

    nxt_s = n;
  end

endmodule
`default_nettype wire

// ===== rtl/osc_outq.sv =====
// Small result queue that takes up to two records per cycle.
`default_nettype none
module osc_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_a,
  input  osc_pkg::osc_out_t rec_a,
  input  logic              push_b,
  input  osc_pkg::osc_out_t rec_b,
  output logic              full2,
  output logic              out_valid,
  input  logic              out_stall,
  output osc_pkg::osc_out_t out_data
);
  import osc_pkg::*;

  osc_out_t               mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [QUEUE_PTR_W:0]   cnt_r, cnt_nxt;
  logic                   pop;
  logic [1:0]             npush;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[head_r];
  assign full2     = (cnt_r > (QUEUE_PTR_W+1)'(QUEUE_DEPTH - 2));
  assign pop       = out_valid && !out_stall;
  assign npush     = {1'b0, push_a} + {1'b0, push_b};
  assign head_nxt  = head_r + QUEUE_PTR_W'(pop);
  assign tail_nxt  = tail_r + QUEUE_PTR_W'(npush);
  assign cnt_nxt   = cnt_r + (QUEUE_PTR_W+1)'(npush) - (QUEUE_PTR_W+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) mem_r[tail_r] <= rec_a;
    if (push_b) mem_r[tail_r + QUEUE_PTR_W'(push_a)] <= rec_b;
  end

endmodule
`default_nettype wire

// ===== rtl/osc_message_stream_parser.sv =====
// Top level: OSC 1.0 message layout checker over a byte stream.
// Output: a record enters the output queue at the edge that accepts its byte
//   and is shown on out_data once the records ahead of it have been taken.
// Throughput: one byte per cycle; in_stall rises only while the 4-entry
//   output queue holds three or more records.
// Reset: synchronous active-low rst_n clears the parse state and the queue.
`default_nettype none
module osc_message_stream_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  osc_pkg::osc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output osc_pkg::osc_out_t out_data
);
  import osc_pkg::*;

  osc_state_t           st_r, st_nxt;
  logic [1:0]           tag_r [MAX_TAGS];
  logic [TAG_IDX_W-1:0] rd_idx;
  logic [1:0]           next_tag;
  osc_tag_wr_t          tag_wr;
  logic                 desc_valid, sum_valid, accept, full2;
  osc_out_t             desc_rec, sum_rec;

  // Hold input while the queue cannot absorb two records.
  assign in_stall = full2;
  assign accept   = in_valid && !in_stall;

  // Inside an argument the next tag read is the one after the current one.
  assign rd_idx   = (st_r.phase >= PH_NUM && st_r.phase <= PH_BLOBPAD) ?
                    TAG_IDX_W'(st_r.cur + 5'd1) : st_r.cur[TAG_IDX_W-1:0];
  assign next_tag = tag_r[rd_idx];

  osc_step u_step (
    .cur_s     (st_r),
    .in_data   (in_data),
    .next_tag  (next_tag),
    .nxt_s     (st_nxt),
    .tag_wr    (tag_wr),
    .desc_valid(desc_valid),
    .desc_rec  (desc_rec),
    .sum_valid (sum_valid),
    .sum_rec   (sum_rec)
  );

  // The all-zero state is the awaiting-first-byte phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  // Tag list: written in order; a read entry is used only below the written count.
  always_ff @(posedge clk) begin
    if (accept && tag_wr.en) tag_r[tag_wr.idx] <= tag_wr.code;
  end

  osc_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_a   (accept && desc_valid),
    .rec_a    (desc_rec),
    .push_b   (accept && sum_valid),
    .rec_b    (sum_rec),
    .full2    (full2),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/osc_checker.sv =====
// Port-level checks for the OSC parser and their bind.
`default_nettype none
module osc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input osc_pkg::osc_out_t out_data
);
  import osc_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.record_kind == out_data.out_last))
    else $error("summary flag and record kind disagree");

  a_desc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.record_kind) |-> (out_data.status == ST_OK &&
      out_data.message_size == 11'd0 && out_data.arg_count == 5'd0))
    else $error("descriptor carries summary fields");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.record_kind && out_data.status != ST_OK) |->
      (out_data.message_size == 11'd0 && out_data.arg_count == 5'd0 &&
       out_data.args_offset == 11'd0))
    else $error("failed summary reports sizes");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind osc_message_stream_parser osc_checker u_osc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
`default_nettype wire
